>>> rtl/xee_pkg.sv
package xee_pkg;

  // Entry slots in the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;
  localparam int unsigned QCNT_BITS   = 3;

  // Default width of the running output count and the capacity reset value.
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam logic [15:0] CAP_RESET      = 16'd256;

  // Byte codes that the escaper handles.
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // Class of one source byte.
  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_APOS
  } kind_t;

  // One classified request held in the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
  } item_t;

  // Class of a source byte.
  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_AMP:  k = KIND_AMP;
      CH_LT:   k = KIND_LT;
      CH_GT:   k = KIND_GT;
      CH_QUOT: k = KIND_QUOT;
      CH_APOS: k = KIND_APOS;
      default: k = KIND_PLAIN;
    endcase
    return k;
  endfunction

  // Number of output bytes that one source byte expands to.
  function automatic logic [2:0] ent_len(input kind_t k);
    logic [2:0] n;
    case (k)
      KIND_AMP:  n = 3'd5;
      KIND_LT:   n = 3'd4;
      KIND_GT:   n = 3'd4;
      KIND_QUOT: n = 3'd6;
      KIND_APOS: n = 3'd6;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  // Output byte at position idx of the expansion; a plain byte passes through.
  function automatic logic [7:0] ent_char(input kind_t k, input logic [2:0] idx,
                                          input logic [7:0] b);
    logic [7:0] c;
    c = b;
    case (k)
      KIND_AMP: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = 8'h61; // a
          3'd2:    c = 8'h6D; // m
          3'd3:    c = 8'h70; // p
          default: c = CH_SEMI;
        endcase
      end
      KIND_LT: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = 8'h6C; // l
          3'd2:    c = 8'h74; // t
          default: c = CH_SEMI;
        endcase
      end
      KIND_GT: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = 8'h67; // g
          3'd2:    c = 8'h74; // t
          default: c = CH_SEMI;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = 8'h71; // q
          3'd2:    c = 8'h75; // u
          3'd3:    c = 8'h6F; // o
          3'd4:    c = 8'h74; // t
          default: c = CH_SEMI;
        endcase
      end
      KIND_APOS: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = 8'h61; // a
          3'd2:    c = 8'h70; // p
          3'd3:    c = 8'h6F; // o
          3'd4:    c = 8'h73; // s
          default: c = CH_SEMI;
        endcase
      end
      default: c = b;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/xml_entity_escaper.sv
// XML entity escaper.
// Input channel (in_valid/in_ready): one source byte per request, in_last on
// the final byte of a string. Output channel (out_valid/out_ready): one
// result per cycle unless the receiver stalls, either an output byte or
// an empty result marked truncated. The characters & < > " ' expand to 4
// to 6 bytes; all other bytes produce one result.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes the output
// capacity, which includes one place kept for a terminator. cfg_ready is
// always high; write it only while the block is idle.
// A request is first written into the queue and its first result then into
// the output register. Results leave at one per cycle unless the receiver
// stalls, set by the single output register; an entity that fits holds the
// back part until all of its bytes are out, while a four-entry queue keeps
// taking requests meanwhile. A stalled receiver holds the output register;
// the queue then fills and in_ready drops. Reset clears the queue, the count
// and the truncation state and sets the capacity to 256.
module xml_entity_escaper #(
  parameter int unsigned COUNT_BITS = xee_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        run_last,
  output logic        truncated,
  output logic [15:0] out_count,
  output logic        string_end
);

  logic [15:0]    capacity;
  logic           q_full;
  logic           push;
  xee_pkg::item_t push_item;
  logic           pop;
  logic           head_valid;
  xee_pkg::item_t head;

  // Capacity register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= xee_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  xee_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  xee_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  xee_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .run_last   (run_last),
    .truncated  (truncated),
    .out_count  (out_count),
    .string_end (string_end)
  );

  // An empty result is always a truncated, single result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> truncated && run_last && (out_byte == 8'd0))
    else $error("empty result without truncation marking");

  // A result that carries a byte is never marked truncated.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> !truncated)
    else $error("byte result marked truncated");

  // The end of a string only comes on the last result of its byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string end on a non-final result");

  // The queue never pops when empty.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

>>> rtl/xee_front.sv
module xee_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              push,
  output xee_pkg::item_t    push_item
);

  // Accept a request whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classify the byte so the back part only has to sequence the expansion.
  always_comb begin
    push_item.data = in_byte;
    push_item.last = in_last;
    push_item.kind = xee_pkg::classify(in_byte);
  end

endmodule

>>> rtl/xee_queue.sv
module xee_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  xee_pkg::item_t         push_item,
  input  logic                   pop,
  output logic                   full,
  output logic                   head_valid,
  output xee_pkg::item_t         head
);

  xee_pkg::item_t                      entries [xee_pkg::QUEUE_DEPTH];
  logic [xee_pkg::QPTR_BITS-1:0]       wr_ptr;
  logic [xee_pkg::QPTR_BITS-1:0]       rd_ptr;
  logic [xee_pkg::QCNT_BITS-1:0]       count;

  assign full       = (count == xee_pkg::QCNT_BITS'(xee_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/xee_back.sv
module xee_back #(
  parameter int unsigned COUNT_BITS = xee_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       capacity,
  input  logic              head_valid,
  input  xee_pkg::item_t    head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              has_byte,
  output logic              run_last,
  output logic              truncated,
  output logic [15:0]       out_count,
  output logic              string_end
);

  // Sums are wide enough for both the count limit and the 16-bit capacity.
  localparam int unsigned SUM_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic [COUNT_BITS-1:0] written_count;
  logic                  stopped;
  logic [2:0]            idx;

  logic [2:0]            len;
  logic [SUM_BITS-1:0]   room_sum;
  logic [COUNT_BITS:0]   max_sum;
  logic                  fits;
  logic                  taking;
  logic                  done;
  logic                  emit;
  logic [COUNT_BITS-1:0] count_inc;
  logic [SUM_BITS-1:0]   count_ext;
  logic [SUM_BITS-1:0]   held_ext;

  // Fit test for a whole expansion, made once at its first output byte.
  always_comb begin
    len      = xee_pkg::ent_len(head.kind);
    room_sum = SUM_BITS'(written_count) + SUM_BITS'(len) + SUM_BITS'(1);
    max_sum  = (COUNT_BITS+1)'(written_count) + (COUNT_BITS+1)'(len);
    fits     = !stopped && (room_sum <= SUM_BITS'(capacity)) && !max_sum[COUNT_BITS];
    taking   = (idx != 3'd0) || fits;
    done     = !taking || (idx == len - 3'd1);
    emit     = head_valid && (!out_valid || out_ready);
    pop      = emit && done;
    count_inc = written_count + 1'b1;
    count_ext = SUM_BITS'(count_inc);
    held_ext  = SUM_BITS'(written_count);
  end

  // Sequencer state: running count, sticky stop and expansion position.
  always_ff @(posedge clk) begin
    if (rst) begin
      written_count <= '0;
      stopped       <= 1'b0;
      idx           <= 3'd0;
    end else if (emit) begin
      idx <= done ? 3'd0 : idx + 3'd1;
      if (done && head.last) begin
        written_count <= '0;
        stopped       <= 1'b0;
      end else if (taking) begin
        written_count <= count_inc;
      end else begin
        stopped <= 1'b1;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      run_last   <= done;
      string_end <= done && head.last;
      if (taking) begin
        out_byte  <= xee_pkg::ent_char(head.kind, idx, head.data);
        has_byte  <= 1'b1;
        truncated <= 1'b0;
        out_count <= count_ext[15:0];
      end else begin
        out_byte  <= 8'd0;
        has_byte  <= 1'b0;
        truncated <= 1'b1;
        out_count <= held_ext[15:0];
      end
    end
  end

endmodule

>>> verif/tb_xml_entity_escaper.sv
`timescale 1ns / 100ps

module tb_xml_entity_escaper;

  localparam int unsigned COUNT_MAX = (1 << xee_pkg::COUNT_BITS_DEF) - 1;
  localparam int unsigned ITEMS_PER_PHASE = 40;
  localparam int unsigned REPORT_LIMIT = 10;

  // One output result of the escaper.
  typedef struct packed {
    logic [7:0]  ch;
    logic        has;
    logic        fin;
    logic        trunc;
    logic [15:0] count;
    logic        eos;
  } esc_result_t;

  // One row of the directed table. Rows with a typed result carry it in res.
  typedef struct {
    logic [15:0] cap;
    logic [7:0]  ch;
    logic        last;
    bit          typed;
    esc_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h01;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        run_last;
  logic        truncated;
  logic [15:0] out_count;
  logic        string_end;

  // Escaper state as the testbench sees it.
  int unsigned esc_capacity = xee_pkg::CAP_RESET;
  int unsigned esc_count = 0;
  bit          esc_stopped = 1'b0;

  esc_result_t escaped_q[$];
  stim_row_t   dir_rows[$];
  int unsigned err_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  xml_entity_escaper u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .run_last   (run_last),
    .truncated  (truncated),
    .out_count  (out_count),
    .string_end (string_end)
  );

  always #6 clk = ~clk;

  // Expands one source byte into the results it should cause and advances the
  // string state. With record clear only the state moves on.
  function automatic void escape_byte(input logic [7:0] ch, input logic last,
                                      input bit record);
    string       ent;
    int unsigned n;
    esc_result_t r;
    ent = "";
    case (ch)
      xee_pkg::CH_AMP:  ent = "&amp;";
      xee_pkg::CH_LT:   ent = "&lt;";
      xee_pkg::CH_GT:   ent = "&gt;";
      xee_pkg::CH_QUOT: ent = "&quot;";
      xee_pkg::CH_APOS: ent = "&apos;";
      default:          ent = "";
    endcase
    n = (ent.len() == 0) ? 1 : ent.len();
    if (!esc_stopped && esc_count + n + 1 <= esc_capacity && esc_count + n <= COUNT_MAX) begin
      for (int i = 0; i < n; i++) begin
        esc_count = esc_count + 1;
        r.ch    = (ent.len() == 0) ? ch : ent[i];
        r.has   = 1'b1;
        r.fin   = (i == n - 1);
        r.trunc = 1'b0;
        r.count = 16'(esc_count);
        r.eos   = (i == n - 1) && last;
        if (record) escaped_q.push_back(r);
      end
    end else begin
      // The whole expansion does not fit, or the string is already cut off.
      esc_stopped = 1'b1;
      r = {8'h00, 1'b0, 1'b1, 1'b1, 16'(esc_count), last};
      if (record) escaped_q.push_back(r);
    end
    if (last) begin
      esc_count = 0;
      esc_stopped = 1'b0;
    end
  endfunction

  function automatic string show(input esc_result_t r);
    return $sformatf("byte=%h has=%b run_last=%b trunc=%b count=%0d end=%b",
                     r.ch, r.has, r.fin, r.trunc, r.count, r.eos);
  endfunction

  function automatic void add_row(input logic [15:0] cap, input logic [7:0] ch,
                                  input logic last, input bit typed,
                                  input esc_result_t res);
    stim_row_t row;
    row.cap = cap;
    row.ch = ch;
    row.last = last;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  // Offers one request and returns at the edge where it is taken.
  task automatic send_item(input logic [7:0] ch, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte <= ch;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every expected result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    esc_capacity = cap;
  endtask

  // Sends one well-formed string; about a third of its bytes need an entity.
  task automatic send_string(input int unsigned len, inout int unsigned sent);
    logic [7:0] ch;
    logic       last;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        case ($urandom_range(0, 4))
          0:       ch = xee_pkg::CH_AMP;
          1:       ch = xee_pkg::CH_LT;
          2:       ch = xee_pkg::CH_GT;
          3:       ch = xee_pkg::CH_QUOT;
          default: ch = xee_pkg::CH_APOS;
        endcase
      end else begin
        ch = 8'($urandom_range(1, 255));
      end
      last = (i == len - 1);
      escape_byte(ch, last, 1'b1);
      send_item(ch, last);
      sent++;
    end
  endtask

  // Receiver side: stall at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    esc_result_t got;
    esc_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {out_byte, has_byte, run_last, truncated, out_count, string_end};
      if (escaped_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT) $display("unexpected result: %s", show(got));
      end else begin
        want = escaped_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= REPORT_LIMIT) begin
            $display("mismatch: expected %s", show(want));
            $display("          got      %s", show(got));
          end
        end
      end
    end
  end

  initial begin
    logic [15:0]  phase_caps[6];
    int unsigned  sent;
    phase_caps = '{16'd20, 16'd65535, 16'd9, 16'd256, 16'd0, 16'd48};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 55;

    // Directed table: every entity, byte extremes, zero and tiny capacity,
    // exact fit, sticky truncation and a capacity change inside a string.
    add_row(16'd256, 8'h41, 1'b0, 1'b1, {8'h41, 1'b1, 1'b1, 1'b0, 16'd1, 1'b0});
    add_row(16'd256, xee_pkg::CH_AMP, 1'b0, 1'b0, '0);
    add_row(16'd256, xee_pkg::CH_LT, 1'b0, 1'b0, '0);
    add_row(16'd256, xee_pkg::CH_GT, 1'b0, 1'b0, '0);
    add_row(16'd256, xee_pkg::CH_QUOT, 1'b0, 1'b0, '0);
    add_row(16'd256, xee_pkg::CH_APOS, 1'b0, 1'b0, '0);
    add_row(16'd256, 8'hFF, 1'b1, 1'b0, '0);
    add_row(16'd256, 8'h01, 1'b1, 1'b1, {8'h01, 1'b1, 1'b1, 1'b0, 16'd1, 1'b1});
    add_row(16'd0, 8'h78, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0});
    add_row(16'd0, xee_pkg::CH_AMP, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 1'b1});
    add_row(16'd2, 8'h61, 1'b0, 1'b1, {8'h61, 1'b1, 1'b1, 1'b0, 16'd1, 1'b0});
    add_row(16'd2, 8'h62, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd1, 1'b0});
    add_row(16'd2, 8'h63, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd1, 1'b1});
    add_row(16'd6, xee_pkg::CH_AMP, 1'b0, 1'b0, '0);
    add_row(16'd65535, 8'h7A, 1'b1, 1'b1, {8'h7A, 1'b1, 1'b1, 1'b0, 16'd6, 1'b1});
    add_row(16'd65535, xee_pkg::CH_APOS, 1'b0, 1'b0, '0);
    add_row(16'd65535, 8'h80, 1'b0, 1'b0, '0);
    add_row(16'd65535, 8'h7F, 1'b1, 1'b0, '0);
    add_row(16'd6, xee_pkg::CH_QUOT, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0});
    add_row(16'd6, 8'h71, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 1'b1});
    add_row(16'd1, 8'h55, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 1'b1});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cap != esc_capacity) write_capacity(dir_rows[i].cap);
      escape_byte(dir_rows[i].ch, dir_rows[i].last, !dir_rows[i].typed);
      if (dir_rows[i].typed) escaped_q.push_back(dir_rows[i].res);
      send_item(dir_rows[i].ch, dir_rows[i].last);
    end

    // Random strings, two capacity settings per idling pattern.
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      case (p / 2)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 55;
        end
        1: begin
          tx_idle_pct = 55;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) send_string($urandom_range(1, 12), sent);
    end

    wait_idle();
    if (escaped_q.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("tb_xml_entity_escaper OK");
    end else begin
      $display("tb_xml_entity_escaper NOT OK");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("tb_xml_entity_escaper NOT OK");
    $finish;
  end

endmodule
